// ----- sv/voc_pkg.sv -----
// Shared types, result codes and signature table for the VOC stream parser.
`timescale 1ns / 1ps

package voc_pkg;

    // Result kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_AUDIO  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // File status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_BAD_SUM   = 3'd3;
    localparam logic [2:0] ST_HDR_SHORT = 3'd4;

    localparam int unsigned SIG_LEN      = 19;
    localparam logic [15:0] SUM_OFFSET   = 16'h1234;
    localparam logic [15:0] HDR_MIN_LEN  = 16'd26;
    localparam int unsigned RATE_NUMER   = 1000000;

    // Header byte positions
    localparam logic [15:0] OFF_HLEN_LO = 16'd20;
    localparam logic [15:0] OFF_HLEN_HI = 16'd21;
    localparam logic [15:0] OFF_VER_LO  = 16'd22;
    localparam logic [15:0] OFF_VER_HI  = 16'd23;
    localparam logic [15:0] OFF_SUM_LO  = 16'd24;
    localparam logic [15:0] OFF_SUM_HI  = 16'd25;

    typedef struct packed {
        logic       step;        // item accepted this cycle
        logic       clear;       // end of file: back to reset values
        logic       hdr_cap;     // capture header fields by offset
        logic       blk_start;   // load block type, clear size
        logic       size_load;   // merge one size byte
        logic       rate_load;   // look up sample rate
        logic       left_dec;    // count down block bytes
        logic       block_done;  // one more sound block finished
        logic       emit;        // a result goes out this cycle
        logic [1:0] kind;
        logic [2:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic off_lt_sig;  // offset still inside the signature
        logic off_is_end;  // offset at the last header field byte
        logic sig_match;
        logic sum_ok;
        logic hdr_lt_min;
        logic hdr_eq_min;
        logic hdr_end;     // last byte of the header extension
        logic byte_zero;
        logic size_done;   // third size byte
        logic size_zero;
        logic sound_ok;    // sound block with room for rate and codec
        logic left_one;    // last byte of the current block
    } t_dp_stat;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] rate_hz;
        logic [7:0]  codec;
        logic [7:0]  audio_byte;
        logic [15:0] block_index;
        logic [2:0]  status;
        logic [15:0] version;
        logic        last_result;
    } t_result;

    function automatic logic [7:0] f_sig_byte(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:    v = 8'h43;
            5'd1:    v = 8'h72;
            5'd2:    v = 8'h65;
            5'd3:    v = 8'h61;
            5'd4:    v = 8'h74;
            5'd5:    v = 8'h69;
            5'd6:    v = 8'h76;
            5'd7:    v = 8'h65;
            5'd8:    v = 8'h20;
            5'd9:    v = 8'h56;
            5'd10:   v = 8'h6F;
            5'd11:   v = 8'h69;
            5'd12:   v = 8'h63;
            5'd13:   v = 8'h65;
            5'd14:   v = 8'h20;
            5'd15:   v = 8'h46;
            5'd16:   v = 8'h69;
            5'd17:   v = 8'h6C;
            5'd18:   v = 8'h65;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/voc_dp.sv -----
// Datapath of the VOC stream parser: offsets, header fields, block counters, rate table.
`timescale 1ns / 1ps

module voc_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_byte,
    input  voc_pkg::t_dp_cmd i_cmd,
    output voc_pkg::t_dp_stat o_stat,
    output voc_pkg::t_result  o_result
);
    import voc_pkg::*;

    logic [15:0] r_off;
    logic [15:0] r_seen;
    logic [1:0]  r_size_cnt;
    logic [7:0]  r_hlen_lo, r_hlen_hi;
    logic [7:0]  r_ver_lo, r_ver_hi;
    logic [7:0]  r_sum_lo;
    logic [7:0]  r_type;
    logic [23:0] r_left;
    logic [19:0] r_rate;

    logic [23:0] n_left;
    logic [15:0] hlen;
    logic [15:0] ver;
    logic [15:0] sum_full;
    logic [16:0] off_plus1;
    logic [19:0] rate_lut [256];

    // Rate table, worked out at elaboration
    for (genvar g = 0; g < 256; g++) begin : g_rate
        localparam int unsigned RATE_G = RATE_NUMER / (256 - g);
        assign rate_lut[g] = 20'(RATE_G);
    end

    assign hlen      = {r_hlen_hi, r_hlen_lo};
    assign ver       = {r_ver_hi, r_ver_lo};
    assign sum_full  = {i_byte, r_sum_lo};
    assign off_plus1 = {1'b0, r_off} + 17'd1;

    always_comb begin
        n_left = r_left;
        case (r_size_cnt)
            2'd0:    n_left = r_left | {16'd0, i_byte};
            2'd1:    n_left = r_left | {8'd0, i_byte, 8'd0};
            default: n_left = r_left | {i_byte, 16'd0};
        endcase
    end

    always_comb begin
        o_stat.off_lt_sig = (r_off < 16'(SIG_LEN));
        o_stat.off_is_end = (r_off == OFF_SUM_HI);
        o_stat.sig_match  = (i_byte == f_sig_byte(r_off[4:0]));
        o_stat.sum_ok     = ((~ver + SUM_OFFSET) == sum_full);
        o_stat.hdr_lt_min = (hlen < HDR_MIN_LEN);
        o_stat.hdr_eq_min = (hlen == HDR_MIN_LEN);
        o_stat.hdr_end    = (off_plus1 >= {1'b0, hlen});
        o_stat.byte_zero  = (i_byte == 8'd0);
        o_stat.size_done  = (r_size_cnt == 2'd2);
        o_stat.size_zero  = (n_left == 24'd0);
        o_stat.sound_ok   = (r_type == 8'd1) && (n_left >= 24'd2);
        o_stat.left_one   = (r_left == 24'd1);
    end

    always_comb begin
        o_result             = '0;
        o_result.kind        = i_cmd.kind;
        o_result.last_result = 1'b1;
        case (i_cmd.kind)
            KIND_START: begin
                o_result.rate_hz     = r_rate;
                o_result.codec       = i_byte;
                o_result.block_index = r_seen;
            end
            KIND_AUDIO: begin
                o_result.audio_byte  = i_byte;
                o_result.block_index = r_seen;
            end
            KIND_STATUS: begin
                o_result.status  = i_cmd.status;
                o_result.version = (i_cmd.status == ST_TOO_SMALL) ? 16'd0 : ver;
            end
            default: ;
        endcase
    end

    // Control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off      <= '0;
            r_seen     <= '0;
            r_size_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_off      <= '0;
            r_seen     <= '0;
            r_size_cnt <= '0;
        end else begin
            if (i_cmd.step && r_off != 16'hFFFF) begin
                r_off <= r_off + 16'd1;
            end
            if (i_cmd.block_done && r_seen != 16'hFFFF) begin
                r_seen <= r_seen + 16'd1;
            end
            if (i_cmd.blk_start) begin
                r_size_cnt <= '0;
            end else if (i_cmd.size_load) begin
                r_size_cnt <= o_stat.size_done ? 2'd0 : r_size_cnt + 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.hdr_cap) begin
            if (r_off == OFF_HLEN_LO) begin
                r_hlen_lo <= i_byte;
                r_hlen_hi <= 8'd0;
            end
            if (r_off == OFF_HLEN_HI) r_hlen_hi <= i_byte;
            if (r_off == OFF_VER_LO)  r_ver_lo  <= i_byte;
            if (r_off == OFF_VER_HI)  r_ver_hi  <= i_byte;
            if (r_off == OFF_SUM_LO)  r_sum_lo  <= i_byte;
        end
        if (i_cmd.blk_start) begin
            r_type <= i_byte;
            r_left <= '0;
        end else if (i_cmd.size_load) begin
            r_left <= n_left;
        end else if (i_cmd.left_dec) begin
            r_left <= r_left - 24'd1;
        end
        if (i_cmd.rate_load) begin
            r_rate <= rate_lut[i_byte];
        end
    end

endmodule

// ----- sv/voc_ctrl.sv -----
// Controller of the VOC stream parser: file phase state machine and command decode.
`timescale 1ns / 1ps

module voc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_last,
    input  voc_pkg::t_dp_stat i_stat,
    output voc_pkg::t_dp_cmd  o_cmd
);
    import voc_pkg::*;

    typedef enum logic [3:0] {
        PH_HEAD, PH_HEADBAD, PH_SKIPHDR, PH_BTYPE, PH_BSIZE,
        PH_STC, PH_SCODEC, PH_SDATA, PH_SKIPBLK, PH_IDLE
    } t_phase;

    t_phase r_phase, n_phase;
    logic   in_header;
    logic [2:0] hdr_status;

    assign in_header = (r_phase == PH_HEAD) || (r_phase == PH_HEADBAD);

    always_comb begin
        if (r_phase == PH_HEADBAD)   hdr_status = ST_BAD_SIG;
        else if (!i_stat.sum_ok)     hdr_status = ST_BAD_SUM;
        else if (i_stat.hdr_lt_min)  hdr_status = ST_HDR_SHORT;
        else                         hdr_status = ST_OK;
    end

    always_comb begin
        o_cmd   = '0;
        n_phase = r_phase;
        if (i_step) begin
            o_cmd.step = 1'b1;
            unique case (r_phase)
                PH_HEAD, PH_HEADBAD: begin
                    o_cmd.hdr_cap = 1'b1;
                    if (i_stat.off_lt_sig) begin
                        if (r_phase == PH_HEAD && !i_stat.sig_match) n_phase = PH_HEADBAD;
                    end else if (i_stat.off_is_end) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.kind   = KIND_STATUS;
                        o_cmd.status = hdr_status;
                        if (hdr_status != ST_OK)    n_phase = PH_IDLE;
                        else if (i_stat.hdr_eq_min) n_phase = PH_BTYPE;
                        else                        n_phase = PH_SKIPHDR;
                    end
                end
                PH_SKIPHDR: begin
                    if (i_stat.hdr_end) n_phase = PH_BTYPE;
                end
                PH_BTYPE: begin
                    if (i_stat.byte_zero) begin
                        n_phase = PH_IDLE;
                    end else begin
                        o_cmd.blk_start = 1'b1;
                        n_phase         = PH_BSIZE;
                    end
                end
                PH_BSIZE: begin
                    o_cmd.size_load = 1'b1;
                    if (i_stat.size_done) begin
                        if (i_stat.size_zero)     n_phase = PH_BTYPE;
                        else if (i_stat.sound_ok) n_phase = PH_STC;
                        else                      n_phase = PH_SKIPBLK;
                    end
                end
                PH_STC: begin
                    o_cmd.rate_load = 1'b1;
                    o_cmd.left_dec  = 1'b1;
                    n_phase         = PH_SCODEC;
                end
                PH_SCODEC: begin
                    o_cmd.left_dec   = 1'b1;
                    o_cmd.emit       = 1'b1;
                    o_cmd.kind       = KIND_START;
                    if (i_stat.left_one) begin
                        o_cmd.block_done = 1'b1;
                        n_phase          = PH_BTYPE;
                    end else begin
                        n_phase = PH_SDATA;
                    end
                end
                PH_SDATA: begin
                    o_cmd.left_dec = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = KIND_AUDIO;
                    if (i_stat.left_one) begin
                        o_cmd.block_done = 1'b1;
                        n_phase          = PH_BTYPE;
                    end
                end
                PH_SKIPBLK: begin
                    o_cmd.left_dec = 1'b1;
                    if (i_stat.left_one) n_phase = PH_BTYPE;
                end
                PH_IDLE: ;
                default: n_phase = PH_HEAD;
            endcase
            // End of file: report a file too short for its header, then start over
            if (i_last) begin
                if (in_header && !o_cmd.emit) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_STATUS;
                    o_cmd.status = ST_TOO_SMALL;
                end
                o_cmd.clear = 1'b1;
                n_phase     = PH_HEAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
        end else begin
            r_phase <= n_phase;
        end
    end

    a_emit_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_step)
        else $error("result emitted without an accepted item");

    a_eof_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_phase == PH_HEAD))
        else $error("parser did not restart after end of file");

    a_status_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.kind == KIND_STATUS) |-> in_header)
        else $error("status result outside the header phase");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> !o_cmd.emit)
        else $error("result emitted after parsing ended");

endmodule

// ----- sv/voc_stream_block_parser_top.sv -----
// VOC stream parser, top level: input handshake, controller, datapath and result register.
// The parser takes one file byte per item and gives at most one result per item: a
// file status with byte 25 (or with the final byte of a file shorter than that), a
// block-start result with the codec byte of each sound block with room for rate and codec,
// and one result for each audio byte. An item is taken every cycle as long as the single
// result register is empty or is being emptied in the same cycle, so sustained rate is
// one item per cycle; each result is registered and appears in the cycle after its item.
// The sample rate comes from a constant 256-entry table indexed by the time-constant byte.
// After the byte marked tlast, phase and counters reset and the next byte begins a new file.
`timescale 1ns / 1ps

module voc_stream_block_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [19:0] rate_hz, [27:20] codec, [35:28] audio_byte, [51:36] block_index,
    // [54:52] status, [70:55] version, [71] zero
    output logic [71:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast    // last_result
);
    import voc_pkg::*;

    logic     s_accept;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_result  result;
    t_result  r_out;
    logic     r_out_valid, n_out_valid;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    voc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s_accept),
        .i_last  (i_s_axis_tlast),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    voc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_s_axis_tdata),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_m_axis_tready) n_out_valid = 1'b0;
        if (cmd.emit)        n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last_result;
    assign o_m_axis_tdata  = {1'b0, r_out.version, r_out.status, r_out.block_index,
                              r_out.audio_byte, r_out.codec, r_out.rate_hz};

endmodule
